/* rtl/core/square_equal_area_splitter_core_assert.svh */
// Assertion macros shared by the splitter core RTL
`ifndef SQUARE_EQUAL_AREA_SPLITTER_CORE_ASSERT_SVH
`define SQUARE_EQUAL_AREA_SPLITTER_CORE_ASSERT_SVH
`ifndef SYNTH
`define SQEAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqeas: same-cycle implication failed");
`define SQEAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqeas: next-cycle implication failed");
`define SQEAS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("sqeas: forbidden condition seen");
`else
`define SQEAS_ASSERT_IMP(lbl, ante, cons)
`define SQEAS_ASSERT_NXT(lbl, ante, cons)
`define SQEAS_ASSERT_NEVER(lbl, expr)
`endif
`endif

/* rtl/core/sqeas_pkg.sv */
// Shared constants, job/divider structs and state encodings of the splitter core
package sqeas_pkg;

  // Port field widths
  localparam int SIDE_FIELD_BITS = 16;
  localparam int BOX_BITS        = 16;
  localparam int K_BITS          = 7;

  // Request limits and internal widths
  localparam int MAX_REGIONS  = 64;
  localparam int SIDE_BITS    = 16;
  localparam int ROOT_BITS    = 4;
  localparam int PART_BITS    = 4;
  localparam int WEIGHT_BITS  = 7;
  localparam int PROD_BITS    = SIDE_BITS + WEIGHT_BITS;
  localparam int DIV_BITS     = PROD_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

  // Job queue between front and back (depth must be a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // One classified request
  typedef struct packed {
    logic                   bad;
    logic [SIDE_BITS-1:0]   side;
    logic [K_BITS-1:0]      count;
    logic [ROOT_BITS-1:0]   root;
    logic [PART_BITS-1:0]   left_cols;
    logic [PART_BITS-1:0]   right_cols;
    logic [WEIGHT_BITS-1:0] weight;
  } job_t;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [K_BITS-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ISSUE,
    ST_WAIT,
    ST_BAND,
    ST_ROW,
    ST_COL,
    ST_ERROR
  } back_state_t;

  typedef enum logic [2:0] {
    OP_SPLIT,
    OP_LEFT_H,
    OP_RIGHT_H,
    OP_LEFT_W,
    OP_RIGHT_W
  } div_op_t;

endpackage

/* rtl/core/sqeas_if.sv */
// Request and box channel interfaces of the splitter core
interface sqeas_req_if import sqeas_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [SIDE_FIELD_BITS-1:0] square_side;
  logic [K_BITS-1:0]          region_count;

  modport source (output valid, output square_side, output region_count, input ready);
  modport sink   (input valid, input square_side, input region_count, output ready);
endinterface

interface sqeas_box_if import sqeas_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BOX_BITS-1:0] box_x;
  logic [BOX_BITS-1:0] box_y;
  logic [BOX_BITS-1:0] box_width;
  logic [BOX_BITS-1:0] box_height;
  logic                last_box;
  logic                request_error;

  modport source (output valid, output box_x, output box_y, output box_width,
                  output box_height, output last_box, output request_error, input ready);
  modport sink   (input valid, input box_x, input box_y, input box_width,
                  input box_height, input last_box, input request_error, output ready);
endinterface

/* rtl/core/sqeas_front.sv */
// Request front end: accept a beat, check it and derive the band split
module sqeas_front import sqeas_pkg::*; (
  sqeas_req_if.sink req,
  input  logic      full,
  output logic      push,
  output job_t      job
);

  // Floor square root of a small count by parallel compares
  function automatic logic [ROOT_BITS-1:0] floor_root(input logic [K_BITS-1:0] val);
    logic [ROOT_BITS-1:0] root;
    root = '0;
    for (int i = 1; i < (1 << ROOT_BITS); i++) begin
      if ((2 * K_BITS)'(i * i) <= (2 * K_BITS)'(val)) begin
        root = ROOT_BITS'(i);
      end
    end
    return root;
  endfunction

  logic [SIDE_BITS-1:0]         side;
  logic [K_BITS-1:0]            count;
  logic [ROOT_BITS-1:0]         root;
  logic [2*ROOT_BITS-1:0]       root_sq;
  logic [K_BITS-1:0]            extra;
  logic [K_BITS-1:0]            left_full;
  logic [K_BITS-1:0]            right_full;
  logic [ROOT_BITS:0]           left_rows;
  logic [ROOT_BITS+PART_BITS:0] weight_full;

  assign req.ready = !full;
  assign push      = req.valid && !full;

  assign side  = SIDE_BITS'(req.square_side);
  assign count = req.region_count;

  // Split k into a full square plus a remainder
  assign root    = floor_root(count);
  assign root_sq = (2 * ROOT_BITS)'(root) * (2 * ROOT_BITS)'(root);
  assign extra   = count - K_BITS'(root_sq);

  // Columns of the taller left band and of the right band
  always_comb begin
    if (extra <= K_BITS'(root)) begin
      left_full  = extra;
      right_full = K_BITS'(root) - extra;
    end else begin
      left_full  = extra - K_BITS'(root);
      right_full = K_BITS'({root, 1'b0}) - extra + K_BITS'(1);
    end
  end

  assign left_rows   = {1'b0, root} + (ROOT_BITS + 1)'(1);
  assign weight_full = (ROOT_BITS + PART_BITS + 1)'(left_rows)
                     * (ROOT_BITS + PART_BITS + 1)'(PART_BITS'(left_full));

  // Pack the classified job
  always_comb begin
    job.bad        = (count == '0)
                  || ((SIDE_BITS + 1)'(count) > (SIDE_BITS + 1)'(side))
                  || (count > K_BITS'(MAX_REGIONS));
    job.side       = side;
    job.count      = count;
    job.root       = root;
    job.left_cols  = PART_BITS'(left_full);
    job.right_cols = PART_BITS'(right_full);
    job.weight     = WEIGHT_BITS'(weight_full);
  end

endmodule

/* rtl/core/sqeas_fifo.sv */
// Short job queue that decouples the front end from the tiling engine
module sqeas_fifo import sqeas_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  `include "square_equal_area_splitter_core_assert.svh"

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;

  assign full    = (fill == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_job = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_BITS + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_BITS + 1)'(1);
      end
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  `SQEAS_ASSERT_NEVER(a_push_when_full, push && full)
  `SQEAS_ASSERT_NEVER(a_pop_when_empty, pop && empty)
  `SQEAS_ASSERT_NEVER(a_fill_in_range, fill > (QPTR_BITS + 1)'(QUEUE_DEPTH))

endmodule

/* rtl/core/sqeas_div.sv */
// Restoring divider, one quotient bit per cycle
module sqeas_div import sqeas_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  `include "square_equal_area_splitter_core_assert.svh"

  logic                    busy;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] steps;
  logic [DIV_BITS-1:0]     quo;
  logic [K_BITS-1:0]       rem;
  logic [K_BITS-1:0]       dvs;
  logic [K_BITS:0]         trial;
  logic [K_BITS:0]         diff;
  logic                    fits;

  // Shift in the next dividend bit and try to subtract
  assign trial = {rem, quo[DIV_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= DIV_CNT_BITS'(DIV_BITS);
      end else if (busy) begin
        steps <= steps - DIV_CNT_BITS'(1);
        if (steps == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient and partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_BITS-2:0], fits};
      rem <= fits ? diff[K_BITS-1:0] : trial[K_BITS-1:0];
    end
  end

  `SQEAS_ASSERT_NEVER(a_start_while_busy, req.start && busy)
  `SQEAS_ASSERT_NXT(a_start_runs, req.start, busy && !done)
  `SQEAS_ASSERT_IMP(a_done_idle, done, !busy)

endmodule

/* rtl/core/sqeas_back.sv */
// Tiling engine: setup divisions, then walk the active bands and drive box beats, or one error beat
module sqeas_back import sqeas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fifo_empty,
  input  job_t        job,
  output logic        fifo_pop,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  sqeas_box_if.source box
);

  `include "square_equal_area_splitter_core_assert.svh"

  back_state_t state;
  back_state_t state_next;
  div_op_t     op;
  logic        band_right;

  // Job fields and setup results
  logic [SIDE_BITS-1:0]   side;
  logic [K_BITS-1:0]      count;
  logic [ROOT_BITS-1:0]   root;
  logic [PART_BITS-1:0]   left_cols;
  logic [PART_BITS-1:0]   right_cols;
  logic [WEIGHT_BITS-1:0] weight;
  logic [PROD_BITS-1:0]   prod;
  logic [SIDE_BITS-1:0]   split;
  logic [SIDE_BITS-1:0]   left_w;
  logic [SIDE_BITS-1:0]   right_w;
  logic [SIDE_BITS-1:0]   left_h;
  logic [SIDE_BITS-1:0]   right_h;

  // Band walk
  logic [SIDE_BITS-1:0] x;
  logic [SIDE_BITS-1:0] y;
  logic [SIDE_BITS-1:0] x0;
  logic [SIDE_BITS-1:0] x1;
  logic [SIDE_BITS-1:0] cw;
  logic [SIDE_BITS-1:0] rh;
  logic [SIDE_BITS-1:0] row_h;
  logic                 last_row;

  // Output register
  logic                box_valid;
  logic [BOX_BITS-1:0] box_xr;
  logic [BOX_BITS-1:0] box_yr;
  logic [BOX_BITS-1:0] box_w;
  logic [BOX_BITS-1:0] box_h;
  logic                box_last;
  logic                box_error;

  logic                 out_free;
  logic                 out_load;
  logic                 left_active;
  logic                 right_active;
  logic                 final_band;
  logic                 div_zero;
  logic                 div_start;
  logic [DIV_BITS-1:0]  div_dividend;
  logic [K_BITS-1:0]    div_divisor;
  logic                 result_take;
  logic [SIDE_BITS-1:0] result_val;
  logic [SIDE_BITS:0]   col_sum;
  logic [SIDE_BITS:0]   row_sum;
  logic                 col_more;
  logic                 row_more;
  logic [SIDE_BITS-1:0] col_w;

  assign out_free     = !box_valid || box.ready;
  assign left_active  = (left_w != '0) && (left_h != '0);
  assign right_active = (right_w != '0) && (right_h != '0);
  assign final_band   = band_right || !right_active;

  assign col_sum  = {1'b0, x} + {1'b0, cw};
  assign col_more = (col_sum < {1'b0, x1});
  assign col_w    = col_more ? cw : (x1 - x);
  assign row_sum  = {1'b0, y} + {1'b0, rh};
  assign row_more = (row_sum < {1'b0, side});

  // Operands of the current setup division (ceilings folded into the dividend of the height and width divisions)
  always_comb begin
    unique case (op)
      OP_SPLIT: begin
        div_dividend = prod;
        div_divisor  = count;
      end
      OP_LEFT_H: begin
        div_dividend = DIV_BITS'(side) + DIV_BITS'(root);
        div_divisor  = K_BITS'(root) + K_BITS'(1);
      end
      OP_RIGHT_H: begin
        div_dividend = DIV_BITS'(side) + DIV_BITS'(root) - DIV_BITS'(1);
        div_divisor  = K_BITS'(root);
      end
      OP_LEFT_W: begin
        div_dividend = DIV_BITS'(split) + DIV_BITS'(left_cols) - DIV_BITS'(1);
        div_divisor  = K_BITS'(left_cols);
      end
      OP_RIGHT_W: begin
        div_dividend = DIV_BITS'(side) - DIV_BITS'(split)
                     + DIV_BITS'(right_cols) - DIV_BITS'(1);
        div_divisor  = K_BITS'(right_cols);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  assign div_zero = (div_divisor == '0);
  assign div_req  = '{start: div_start, dividend: div_dividend, divisor: div_divisor};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!fifo_empty) begin
          state_next = job.bad ? ST_ERROR : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (div_zero) begin
          state_next = (op == OP_RIGHT_W) ? ST_BAND : ST_ISSUE;
        end else begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_next = (op == OP_RIGHT_W) ? ST_BAND : ST_ISSUE;
        end
      end
      ST_BAND: begin
        if (band_right || left_active) begin
          state_next = ST_ROW;
        end else if (right_active) begin
          state_next = ST_BAND;
        end else begin
          state_next = ST_ERROR;
        end
      end
      ST_ROW: begin
        state_next = ST_COL;
      end
      ST_COL: begin
        if (out_free && !col_more) begin
          if (!last_row) begin
            state_next = ST_ROW;
          end else if (!band_right && right_active) begin
            state_next = ST_BAND;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    fifo_pop    = (state == ST_IDLE) && !fifo_empty;
    div_start   = (state == ST_ISSUE) && !div_zero;
    result_take = ((state == ST_ISSUE) && div_zero) || ((state == ST_WAIT) && div_rsp.done);
    result_val  = (state == ST_WAIT) ? SIDE_BITS'(div_rsp.quotient) : '0;
    out_load    = ((state == ST_COL) || (state == ST_ERROR)) && out_free;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op         <= OP_SPLIT;
      band_right <= 1'b0;
      box_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (fifo_pop) begin
        op         <= OP_SPLIT;
        band_right <= 1'b0;
      end else if (result_take) begin
        unique case (op)
          OP_SPLIT:   op <= OP_LEFT_H;
          OP_LEFT_H:  op <= OP_RIGHT_H;
          OP_RIGHT_H: op <= OP_LEFT_W;
          OP_LEFT_W:  op <= OP_RIGHT_W;
          default:    op <= OP_SPLIT;
        endcase
      end
      // Move to the right band when the left one is skipped or done
      if ((state == ST_BAND) && !band_right && !left_active && right_active) begin
        band_right <= 1'b1;
      end
      if ((state == ST_COL) && out_free && !col_more && last_row && !band_right
          && right_active) begin
        band_right <= 1'b1;
      end
      if (out_load) begin
        box_valid <= 1'b1;
      end else if (box.ready) begin
        box_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      side       <= job.side;
      count      <= job.count;
      root       <= job.root;
      left_cols  <= job.left_cols;
      right_cols <= job.right_cols;
      weight     <= job.weight;
    end
    if (state == ST_MUL) begin
      prod <= PROD_BITS'(side) * PROD_BITS'(weight);
    end
    // Hold each setup result
    if (result_take) begin
      unique case (op)
        OP_SPLIT:   split   <= result_val;
        OP_LEFT_H:  left_h  <= result_val;
        OP_RIGHT_H: right_h <= result_val;
        OP_LEFT_W:  left_w  <= result_val;
        OP_RIGHT_W: right_w <= result_val;
        default:    split   <= result_val;
      endcase
    end
    // Load band geometry
    if (state == ST_BAND) begin
      y <= '0;
      if (band_right) begin
        x0 <= split;
        x1 <= side;
        cw <= right_w;
        rh <= right_h;
      end else begin
        x0 <= '0;
        x1 <= split;
        cw <= left_w;
        rh <= left_h;
      end
    end
    // Start a row: the last row takes what is left
    if (state == ST_ROW) begin
      x        <= x0;
      row_h    <= row_more ? rh : (side - y);
      last_row <= !row_more;
    end
    // Advance along the row as beats leave
    if ((state == ST_COL) && out_free) begin
      x <= col_sum[SIDE_BITS-1:0];
      if (!col_more) begin
        y <= row_sum[SIDE_BITS-1:0];
      end
    end
    if (out_load) begin
      if (state == ST_ERROR) begin
        box_xr    <= '0;
        box_yr    <= '0;
        box_w     <= '0;
        box_h     <= '0;
        box_last  <= 1'b1;
        box_error <= 1'b1;
      end else begin
        box_xr    <= BOX_BITS'(x);
        box_yr    <= BOX_BITS'(y);
        box_w     <= BOX_BITS'(col_w);
        box_h     <= BOX_BITS'(row_h);
        box_last  <= !col_more && last_row && final_band;
        box_error <= 1'b0;
      end
    end
  end

  assign box.valid         = box_valid;
  assign box.box_x         = box_xr;
  assign box.box_y         = box_yr;
  assign box.box_width     = box_w;
  assign box.box_height    = box_h;
  assign box.last_box      = box_last;
  assign box.request_error = box_error;

  `SQEAS_ASSERT_IMP(a_pop_only_idle, fifo_pop, state == ST_IDLE)
  `SQEAS_ASSERT_IMP(a_error_is_last, box_valid && box_error, box_last && box_w == '0)
  `SQEAS_ASSERT_IMP(a_box_not_empty, box_valid && !box_error, box_w != '0 && box_h != '0)

endmodule

/* rtl/core/square_equal_area_splitter_core.sv */
// Setup per valid request: pop, one product, then five divisions on one shared restoring
// divider (a division with a zero column count skips the divider and gives zero); then the
// bands, rows and boxes are walked in turn. An invalid request gives one error beat instead.
// Requests: one at a time in the tiling engine, which takes no new one until it is through
// with the last; a two-deep job queue in front keeps taking requests while it is not full.
// Reset: synchronous, active high; clears control state only, no clearing pass.
module square_equal_area_splitter_core import sqeas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sqeas_req_if.sink   req,
  sqeas_box_if.source box
);

  logic     push;
  job_t     push_job;
  logic     full;
  logic     pop;
  job_t     pop_job;
  logic     empty;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Accept and classify requests
  sqeas_front u_front (
    .req  (req),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  // Decouple front and back
  sqeas_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // Shared setup divider
  sqeas_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Tile the square and drive box beats
  sqeas_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (empty),
    .job        (pop_job),
    .fifo_pop   (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .box        (box)
  );

endmodule
